@@ rtl/principal_name_splitter_defines.svh @@
// ----------------------------------------------------------------------------
// Principal name splitter assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef PRINCIPAL_NAME_SPLITTER_DEFINES_SVH
`define PRINCIPAL_NAME_SPLITTER_DEFINES_SVH

// Same-cycle implication
`define PNS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pns assertion failed");

// Next-cycle implication
`define PNS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pns assertion failed");

`endif

@@ rtl/pns_pkg.sv @@
// ----------------------------------------------------------------------------
// Principal name splitter package
// Field codes, separator characters, size defaults and the result record.
// ----------------------------------------------------------------------------
package pns_pkg;

    // Default field size limits
    localparam int NAME_MAX_BYTES_DEF     = 40;
    localparam int INSTANCE_MAX_BYTES_DEF = 40;
    localparam int REALM_MAX_BYTES_DEF    = 40;

    // Separator and escape characters
    localparam logic [7:0] CH_ESCAPE = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_AT     = 8'h40;

    // Field codes
    localparam logic [1:0] FIELD_NAME     = 2'd0;
    localparam logic [1:0] FIELD_INSTANCE = 2'd1;
    localparam logic [1:0] FIELD_REALM    = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One result beat as it travels from front to back
    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic [1:0] out_field;
        logic       clear_instance;
        logic       done_res;
        logic       status;
    } pns_rec_t;

    // Queue status seen by its neighbours
    typedef struct packed {
        logic full;
        logic not_empty;
    } pns_q_stat_t;

endpackage

@@ rtl/pns_front.sv @@
// ----------------------------------------------------------------------------
// Principal name splitter front end
// Accepts bytes, one per cycle while the queue has room, classifies them and
// runs the field and error state, pushing one result record per accepted beat.
// ----------------------------------------------------------------------------
module pns_front #(
    parameter int NAME_MAX_BYTES     = pns_pkg::NAME_MAX_BYTES_DEF,
    parameter int INSTANCE_MAX_BYTES = pns_pkg::INSTANCE_MAX_BYTES_DEF,
    parameter int REALM_MAX_BYTES    = pns_pkg::REALM_MAX_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_byte_in,
    input  logic                 s_end_of_name,
    input  pns_pkg::pns_q_stat_t q_stat,
    output logic                 push,
    output pns_pkg::pns_rec_t    push_rec
);
    import pns_pkg::*;

    localparam int LEN_MAX_A = (NAME_MAX_BYTES > INSTANCE_MAX_BYTES) ?
                               NAME_MAX_BYTES : INSTANCE_MAX_BYTES;
    localparam int LEN_MAX   = (LEN_MAX_A > REALM_MAX_BYTES) ? LEN_MAX_A : REALM_MAX_BYTES;
    localparam int LEN_W     = $clog2(LEN_MAX + 1);
    localparam int TOTAL     = NAME_MAX_BYTES + INSTANCE_MAX_BYTES + REALM_MAX_BYTES;
    localparam int TOT_W     = $clog2(TOTAL + 2);

    localparam logic [LEN_W-1:0] NAME_LIM  = LEN_W'(NAME_MAX_BYTES);
    localparam logic [LEN_W-1:0] INST_LIM  = LEN_W'(INSTANCE_MAX_BYTES);
    localparam logic [LEN_W-1:0] REALM_LIM = LEN_W'(REALM_MAX_BYTES);
    localparam logic [TOT_W-1:0] TOT_LIM   = TOT_W'(TOTAL);

    typedef enum logic [3:0] {
        CLS_ESCAPE = 4'b0001,
        CLS_DOT    = 4'b0010,
        CLS_AT     = 4'b0100,
        CLS_OTHER  = 4'b1000
    } pns_cls_t;

    logic [1:0]       field_reg, field_next;
    logic             esc_reg, esc_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic             err_reg, err_next;

    pns_cls_t         cls;
    logic [LEN_W-1:0] limit;
    logic             keep;
    logic             clr;
    logic             err;

    // Accept while the queue has room
    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    // Classify the incoming byte
    always_comb begin
        priority if (s_byte_in == CH_ESCAPE) begin
            cls = CLS_ESCAPE;
        end else if (s_byte_in == CH_DOT) begin
            cls = CLS_DOT;
        end else if (s_byte_in == CH_AT) begin
            cls = CLS_AT;
        end else begin
            cls = CLS_OTHER;
        end
    end

    // Advance field, escape and length state
    always_comb begin
        field_next = field_reg;
        esc_next   = esc_reg;
        len_next   = len_reg;
        tot_next   = tot_reg;
        err_next   = err_reg;
        keep       = 1'b0;
        clr        = 1'b0;
        err        = 1'b0;
        limit      = REALM_LIM;
        push_rec   = '0;

        if (s_end_of_name) begin
            // Report status and rearm for the next name
            field_next        = FIELD_NAME;
            esc_next          = 1'b0;
            len_next          = '0;
            tot_next          = '0;
            err_next          = 1'b0;
            push_rec.done_res = 1'b1;
            push_rec.status   = err_reg;
        end else begin
            if (!err_reg) begin
                if (tot_reg <= TOT_LIM) begin
                    tot_next = tot_reg + TOT_W'(1);
                end
                if (tot_next > TOT_LIM) begin
                    err = 1'b1;
                end else if (esc_reg) begin
                    esc_next = 1'b0;
                    keep     = 1'b1;
                end else begin
                    unique case (cls)
                        CLS_ESCAPE: esc_next = 1'b1;
                        CLS_DOT: begin
                            if (field_reg == FIELD_NAME) begin
                                if (len_reg == '0) begin
                                    err = 1'b1;
                                end else begin
                                    field_next = FIELD_INSTANCE;
                                    len_next   = '0;
                                end
                            end else begin
                                keep = 1'b1;
                            end
                        end
                        CLS_AT: begin
                            if (field_reg == FIELD_NAME) begin
                                if (len_reg == '0) begin
                                    err = 1'b1;
                                end else begin
                                    clr        = 1'b1;
                                    field_next = FIELD_REALM;
                                    len_next   = '0;
                                end
                            end else if (field_reg == FIELD_INSTANCE) begin
                                field_next = FIELD_REALM;
                                len_next   = '0;
                            end else begin
                                err = 1'b1;
                            end
                        end
                        default: keep = 1'b1;
                    endcase
                end

                // Check the field size limit after this byte
                if (field_next == FIELD_NAME) begin
                    limit = NAME_LIM;
                end else if (field_next == FIELD_INSTANCE) begin
                    limit = INST_LIM;
                end
                if (!err) begin
                    if (keep) begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    if (len_next >= limit) begin
                        err = 1'b1;
                    end
                end
                if (err) begin
                    err_next = 1'b1;
                    keep     = 1'b0;
                    clr      = 1'b0;
                end
            end
            push_rec.char_valid     = keep;
            push_rec.out_char       = keep ? s_byte_in : 8'h00;
            push_rec.out_field      = field_next;
            push_rec.clear_instance = clr;
            push_rec.status         = err_next;
        end
    end

    // Hold state between accepted beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg <= FIELD_NAME;
            esc_reg   <= 1'b0;
            len_reg   <= '0;
            tot_reg   <= '0;
            err_reg   <= 1'b0;
        end else if (push) begin
            field_reg <= field_next;
            esc_reg   <= esc_next;
            len_reg   <= len_next;
            tot_reg   <= tot_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ rtl/pns_queue.sv @@
// ----------------------------------------------------------------------------
// Principal name splitter queue
// Short first-in first-out buffer of result records between front and back.
// ----------------------------------------------------------------------------
module pns_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  pns_pkg::pns_rec_t    push_rec,
    input  logic                 pop,
    output pns_pkg::pns_rec_t    pop_rec,
    output pns_pkg::pns_q_stat_t q_stat
);
    import pns_pkg::*;

    pns_rec_t               mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full      = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_stat.not_empty = (cnt_reg != '0);
    assign pop_rec          = mem[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the record
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

@@ rtl/pns_back.sv @@
// ----------------------------------------------------------------------------
// Principal name splitter back end
// Drains the queue into the output register and drives the result channel.
// ----------------------------------------------------------------------------
module pns_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pns_pkg::pns_q_stat_t q_stat,
    input  pns_pkg::pns_rec_t    pop_rec,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_char_valid,
    output logic [7:0]           m_out_char,
    output logic [1:0]           m_out_field,
    output logic                 m_clear_instance,
    output logic                 m_done_res,
    output logic                 m_status
);
    import pns_pkg::*;

    logic     valid_reg, valid_next;
    pns_rec_t rec_reg;

    // Load a new beat when the output register is empty or being taken
    assign pop        = q_stat.not_empty && (!valid_reg || m_ready);
    assign valid_next = pop ? 1'b1 : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= pop_rec;
        end
    end

    assign m_valid          = valid_reg;
    assign m_char_valid     = rec_reg.char_valid;
    assign m_out_char       = rec_reg.out_char;
    assign m_out_field      = rec_reg.out_field;
    assign m_clear_instance = rec_reg.clear_instance;
    assign m_done_res       = rec_reg.done_res;
    assign m_status         = rec_reg.status;

endmodule

@@ rtl/principal_name_splitter.sv @@
// ----------------------------------------------------------------------------
// Principal name splitter
// Splits name[.instance][@realm] into tagged characters with sticky status.
// ----------------------------------------------------------------------------
// One byte beat is taken every cycle while the queue has room and yields one
// result beat, through the queue and the output register. The front end sets
// the rate; it classifies the byte and updates the field, escape, length and
// error state. A two-entry queue and the output register part the two sides,
// so input keeps flowing while a result waits, until the queue is full.
// Bytes already emitted must be discarded when the terminator reports status 1.
// ----------------------------------------------------------------------------
`include "principal_name_splitter_defines.svh"

module principal_name_splitter #(
    parameter int NAME_MAX_BYTES     = pns_pkg::NAME_MAX_BYTES_DEF,
    parameter int INSTANCE_MAX_BYTES = pns_pkg::INSTANCE_MAX_BYTES_DEF,
    parameter int REALM_MAX_BYTES    = pns_pkg::REALM_MAX_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_end_of_name,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_char_valid,
    output logic [7:0] m_out_char,
    output logic [1:0] m_out_field,
    output logic       m_clear_instance,
    output logic       m_done_res,
    output logic       m_status
);
    import pns_pkg::*;

    pns_q_stat_t q_stat;
    pns_rec_t    push_rec;
    pns_rec_t    pop_rec;
    logic        push;
    logic        pop;

    pns_front #(
        .NAME_MAX_BYTES    (NAME_MAX_BYTES),
        .INSTANCE_MAX_BYTES(INSTANCE_MAX_BYTES),
        .REALM_MAX_BYTES   (REALM_MAX_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .s_end_of_name(s_end_of_name),
        .q_stat       (q_stat),
        .push         (push),
        .push_rec     (push_rec)
    );

    pns_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_rec(push_rec),
        .pop     (pop),
        .pop_rec (pop_rec),
        .q_stat  (q_stat)
    );

    pns_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .pop_rec         (pop_rec),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_valid    (m_char_valid),
        .m_out_char      (m_out_char),
        .m_out_field     (m_out_field),
        .m_clear_instance(m_clear_instance),
        .m_done_res      (m_done_res),
        .m_status        (m_status)
    );

    // A terminator beat never carries a character
    `PNS_ASSERT_NOW(a_done_no_char, m_valid && m_done_res, !m_char_valid && !m_clear_instance)
    // Clearing the instance always moves into the realm without a character
    `PNS_ASSERT_NOW(a_clr_realm, m_valid && m_clear_instance, (m_out_field == FIELD_REALM) && !m_char_valid)
    // A dropped character is reported as zero
    `PNS_ASSERT_NOW(a_zero_char, m_valid && !m_char_valid, m_out_char == 8'h00)
    // A full queue with a stalled output keeps the output beat
    `PNS_ASSERT_NEXT(a_full_hold, q_stat.full && m_valid && !m_ready, m_valid && !s_ready)

endmodule

@@ tb/sv/principal_name_splitter_tb.sv @@
// ----------------------------------------------------------------------------
// Principal name splitter testbench
// Sends principal names one byte beat at a time and checks every result beat
// against an in-bench model of the field, escape, length and error logic, or
// against a row's own expected beat in the short corner-case vector table.
// Random names follow, well-formed and broken, under several idle and stall phases.
// ----------------------------------------------------------------------------
module principal_name_splitter_tb;

    import pns_pkg::*;

    localparam int TOTAL_BYTES_MAX = NAME_MAX_BYTES_DEF + INSTANCE_MAX_BYTES_DEF
                                     + REALM_MAX_BYTES_DEF;
    localparam int RANDOM_BEATS    = 1000;
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_IDLE  [4] = '{0, 53, 0, 13};
    localparam int PHASE_STALL [4] = '{0, 0, 53, 13};

    // One row of the vector table; want is only used when typed is set
    typedef struct {
        logic [7:0] data;
        logic       eon;
        bit         typed;
        pns_rec_t   want;
    } vector_row_t;

    localparam pns_rec_t NO_WANT = '0;

    logic       aclk;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_in        = 8'h00;
    logic       s_end_of_name    = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic       m_char_valid;
    logic [7:0] m_out_char;
    logic [1:0] m_out_field;
    logic       m_clear_instance;
    logic       m_done_res;
    logic       m_status;

    // Model state of the splitter
    logic [1:0] cur_field    = FIELD_NAME;
    logic       escape_armed = 1'b0;
    logic [5:0] field_len    = '0;
    logic [6:0] total_len    = '0;
    logic       error_seen   = 1'b0;

    pns_rec_t   awaited_results [$];
    int         error_count     = 0;
    int         beats_sent      = 0;
    int         cycle_count     = 0;
    int         sender_idle_pct = 0;
    int         stall_pct       = 0;
    int         hold_left       = 0;
    bit         hold_armed      = 1'b0;

    vector_row_t vectors [22] = '{
        // terminator straight after reset: clean status
        '{8'hA5, 1'b1, 1'b1, '{1'b0, 8'h00, FIELD_NAME, 1'b0, 1'b1, 1'b0}},
        // dot with empty name, then a dropped byte, then the error status
        '{CH_DOT, 1'b0, 1'b1, '{1'b0, 8'h00, FIELD_NAME, 1'b0, 1'b0, 1'b1}},
        '{8'h61, 1'b0, 1'b1, '{1'b0, 8'h00, FIELD_NAME, 1'b0, 1'b0, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, FIELD_NAME, 1'b0, 1'b1, 1'b1}},
        // at-sign with empty name
        '{CH_AT, 1'b0, 1'b1, '{1'b0, 8'h00, FIELD_NAME, 1'b0, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, '{1'b0, 8'h00, FIELD_NAME, 1'b0, 1'b1, 1'b1}},
        // zero and all-ones bytes are plain name data
        '{8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, FIELD_NAME, 1'b0, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{1'b1, 8'hFF, FIELD_NAME, 1'b0, 1'b0, 1'b0}},
        // open instance, literal dot, escaped at-sign, open realm
        '{CH_DOT,    1'b0, 1'b0, NO_WANT},
        '{CH_DOT,    1'b0, 1'b0, NO_WANT},
        '{CH_ESCAPE, 1'b0, 1'b0, NO_WANT},
        '{CH_AT,     1'b0, 1'b0, NO_WANT},
        '{CH_AT,     1'b0, 1'b0, NO_WANT},
        // literal dot and escaped backslash in the realm, then second at-sign
        '{CH_DOT,    1'b0, 1'b0, NO_WANT},
        '{CH_ESCAPE, 1'b0, 1'b0, NO_WANT},
        '{CH_ESCAPE, 1'b0, 1'b0, NO_WANT},
        '{CH_AT,     1'b0, 1'b0, NO_WANT},
        '{8'h00,     1'b1, 1'b0, NO_WANT},
        // at-sign straight after the name clears the instance; trailing escape
        '{8'h6B,     1'b0, 1'b0, NO_WANT},
        '{CH_AT,     1'b0, 1'b0, NO_WANT},
        '{CH_ESCAPE, 1'b0, 1'b0, NO_WANT},
        '{8'h3C,     1'b1, 1'b0, NO_WANT}
    };

    principal_name_splitter u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_end_of_name    (s_end_of_name),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_char_valid     (m_char_valid),
        .m_out_char       (m_out_char),
        .m_out_field      (m_out_field),
        .m_clear_instance (m_clear_instance),
        .m_done_res       (m_done_res),
        .m_status         (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Work out the result beat of one byte and advance the model state
    function automatic pns_rec_t split_step(input logic [7:0] c, input logic eon);
        pns_rec_t res;
        bit       keep;
        bit       clr;
        bit       err;
        int       lim;
        res  = '0;
        keep = 1'b0;
        clr  = 1'b0;
        err  = 1'b0;
        if (eon) begin
            res.done_res = 1'b1;
            res.status   = error_seen;
            cur_field    = FIELD_NAME;
            escape_armed = 1'b0;
            field_len    = '0;
            total_len    = '0;
            error_seen   = 1'b0;
            return res;
        end
        if (!error_seen) begin
            // saturate just above the total
            if (total_len <= TOTAL_BYTES_MAX)
                total_len++;
            if (total_len > TOTAL_BYTES_MAX) begin
                err = 1'b1;
            end else if (escape_armed) begin
                escape_armed = 1'b0;
                keep = 1'b1;
            end else if (c == CH_ESCAPE) begin
                escape_armed = 1'b1;
            end else if (c == CH_DOT) begin
                if (cur_field == FIELD_NAME) begin
                    if (field_len == 0) begin
                        err = 1'b1;
                    end else begin
                        cur_field = FIELD_INSTANCE;
                        field_len = '0;
                    end
                end else begin
                    keep = 1'b1;
                end
            end else if (c == CH_AT) begin
                if (cur_field == FIELD_NAME) begin
                    if (field_len == 0) begin
                        err = 1'b1;
                    end else begin
                        clr       = 1'b1;
                        cur_field = FIELD_REALM;
                        field_len = '0;
                    end
                end else if (cur_field == FIELD_INSTANCE) begin
                    cur_field = FIELD_REALM;
                    field_len = '0;
                end else begin
                    err = 1'b1;
                end
            end else begin
                keep = 1'b1;
            end

            // field size limit
            if (!err) begin
                if (keep)
                    field_len++;
                lim = (cur_field == FIELD_NAME)     ? NAME_MAX_BYTES_DEF :
                      (cur_field == FIELD_INSTANCE) ? INSTANCE_MAX_BYTES_DEF :
                                                      REALM_MAX_BYTES_DEF;
                if (field_len >= lim)
                    err = 1'b1;
            end
            if (err) begin
                error_seen = 1'b1;
                keep       = 1'b0;
                clr        = 1'b0;
            end
        end
        res.char_valid     = keep;
        res.out_char       = keep ? c : 8'h00;
        res.out_field      = cur_field;
        res.clear_instance = clr;
        res.status         = error_seen;
        return res;
    endfunction

    // Offer one byte beat, hold it until taken, then log its expected result
    task automatic send_beat(input logic [7:0] data, input logic eon,
                             input bit typed = 1'b0, input pns_rec_t want = '0);
        pns_rec_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_byte_in     <= data;
        s_end_of_name <= eon;
        do @(posedge aclk); while (!s_ready);
        predicted = split_step(data, eon);
        awaited_results.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // One component character; separators and escapes in the data get escaped
    // unless the raw share lets them through and break the name
    task automatic send_char(input int esc_pct, input int raw_pct);
        logic [7:0] c;
        case ($urandom_range(19))
            0:       c = CH_DOT;
            1:       c = CH_AT;
            2:       c = CH_ESCAPE;
            default: c = 8'($urandom_range(255));
        endcase
        if ($urandom_range(99) < raw_pct) begin
            send_beat(c, 1'b0);
        end else if (c == CH_DOT || c == CH_AT || c == CH_ESCAPE
                     || $urandom_range(99) < esc_pct) begin
            send_beat(CH_ESCAPE, 1'b0);
            send_beat(c, 1'b0);
        end else begin
            send_beat(c, 1'b0);
        end
    endtask

    // A whole name; a negative length leaves that component out
    task automatic send_name(input int name_len, input int inst_len,
                             input int realm_len, input int esc_pct, input int raw_pct);
        for (int i = 0; i < name_len; i++)
            send_char(esc_pct, raw_pct);
        if (inst_len >= 0) begin
            send_beat(CH_DOT, 1'b0);
            for (int i = 0; i < inst_len; i++)
                send_char(esc_pct, raw_pct);
        end
        if (realm_len >= 0) begin
            send_beat(CH_AT, 1'b0);
            for (int i = 0; i < realm_len; i++)
                send_char(esc_pct, raw_pct);
        end
        if ($urandom_range(15) == 0)
            send_beat(CH_ESCAPE, 1'b0);
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            error_count++;
        end
    endfunction

    // Receiver: long hold-off when armed, else random stalls
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left  = HOLD_CYCLES - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        pns_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result beat with nothing expected");
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("char_valid", 8'(want.char_valid), 8'(m_char_valid));
                check_field("out_char", want.out_char, m_out_char);
                check_field("out_field", 8'(want.out_field), 8'(m_out_field));
                check_field("clear_instance", 8'(want.clear_instance),
                            8'(m_clear_instance));
                check_field("done_res", 8'(want.done_res), 8'(m_done_res));
                check_field("status", 8'(want.status), 8'(m_status));
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int random_start;
        int mode;
        int name_len;
        int inst_len;
        int realm_len;
        int esc_pct;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // vector table
        foreach (vectors[i])
            send_beat(vectors[i].data, vectors[i].eon, vectors[i].typed, vectors[i].want);
        // name reaching its size limit, then total length overrun via escapes
        send_name(NAME_MAX_BYTES_DEF, -1, -1, 0, 0);
        send_name(20, 20, 20, 100, 0);

        // random names over the idling phases
        random_start = beats_sent;
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = PHASE_IDLE[p];
            stall_pct       = PHASE_STALL[p];
            if (p == 0)
                hold_armed = 1'b1;
            while (beats_sent < random_start + (p + 1) * RANDOM_BEATS / 4) begin
                mode = $urandom_range(99);
                if (mode < 8) begin
                    // noise: raw bytes then a terminator
                    repeat ($urandom_range(6))
                        send_beat(8'($urandom_range(255)), 1'b0);
                    send_beat(8'($urandom_range(255)), 1'b1);
                end else begin
                    name_len  = ($urandom_range(9) == 0) ? $urandom_range(30, 45)
                                                         : $urandom_range(0, 8);
                    inst_len  = ($urandom_range(1) == 0) ? -1
                              : ($urandom_range(9) == 0) ? $urandom_range(30, 45)
                                                         : $urandom_range(0, 8);
                    realm_len = ($urandom_range(1) == 0) ? -1
                              : ($urandom_range(9) == 0) ? $urandom_range(30, 45)
                                                         : $urandom_range(0, 8);
                    esc_pct   = ($urandom_range(3) == 0) ? $urandom_range(30, 100)
                                                         : $urandom_range(0, 10);
                    send_name(name_len, inst_len, realm_len, esc_pct,
                              (mode < 20) ? 10 : 0);
                end
            end
        end
        s_valid <= 1'b0;

        // drain
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
